// File: rtl/window_spectrum_accumulator_assert.svh
// assertion macros used by the rtl top level
`ifndef WINDOW_SPECTRUM_ACCUMULATOR_ASSERT_SVH
`define WINDOW_SPECTRUM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define WSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define WSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/wsa_pkg.sv
package wsa_pkg;

   localparam logic ACT_ACC  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [15:0] SAT_MAX = 16'hFFFF;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   typedef struct packed {
      logic        action;
      logic [9:0]  bin;
      logic [15:0] b_cumulative;
      logic [15:0] m_cumulative;
   } req_type;

   typedef struct packed {
      logic [15:0] m_count;
      logic [15:0] b_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_ACC,
      CMD_READ,
      CMD_NULL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [9:0]   bin;
      logic [15:0]  dm;
      logic [15:0]  db;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } back_state_type;

   function automatic logic [15:0] sat16(input logic [31:0] v);
      logic [15:0] r;
      r = (v[31:16] != 16'd0) ? SAT_MAX : v[15:0];
      return r;
   endfunction

endpackage

// File: rtl/wsa_fifo.sv
module wsa_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsa_pkg::cmd_type       push_data,
   input  logic                   pop,
   output wsa_pkg::cmd_type       head,
   output wsa_pkg::fifo_stat_type stat
);

   wsa_pkg::cmd_type              entry_ff [wsa_pkg::QDEPTH];
   logic [wsa_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wsa_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wsa_pkg::QPTR_W:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (wsa_pkg::QPTR_W+1)'(wsa_pkg::QDEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// File: rtl/wsa_front.sv
module wsa_front #(
   parameter int BINS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wsa_pkg::req_type       req_data,
   input  logic                   init_done,
   input  wsa_pkg::fifo_stat_type q_stat,
   output logic                   q_push,
   output wsa_pkg::cmd_type       q_cmd
);

   logic [15:0] prev_m_ff, prev_m_in;
   logic [15:0] prev_b_ff, prev_b_in;
   logic        accept;
   logic        in_range;
   logic        is_acc;

   assign req_ready = init_done && !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign in_range  = (32'(req_data.bin) < 32'(BINS));
   assign is_acc    = (req_data.action == wsa_pkg::ACT_ACC);

   always_comb begin
      q_cmd.bin = in_range ? req_data.bin : '0;
      if (is_acc) begin
         q_cmd.kind = wsa_pkg::CMD_ACC;
      end else if (in_range) begin
         q_cmd.kind = wsa_pkg::CMD_READ;
      end else begin
         q_cmd.kind = wsa_pkg::CMD_NULL;
      end
      // first bin takes the raw counts, later bins the wrapped difference
      if (req_data.bin == '0) begin
         q_cmd.dm = req_data.m_cumulative;
         q_cmd.db = req_data.b_cumulative;
      end else begin
         q_cmd.dm = req_data.m_cumulative - prev_m_ff;
         q_cmd.db = req_data.b_cumulative - prev_b_ff;
      end
      q_push    = accept && (!is_acc || in_range);
      prev_m_in = (accept && is_acc) ? req_data.m_cumulative : prev_m_ff;
      prev_b_in = (accept && is_acc) ? req_data.b_cumulative : prev_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_m_ff <= '0;
         prev_b_ff <= '0;
      end else begin
         prev_m_ff <= prev_m_in;
         prev_b_ff <= prev_b_in;
      end
   end

endmodule

// File: rtl/wsa_back.sv
module wsa_back #(
   parameter int BINS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wsa_pkg::cmd_type       q_cmd,
   input  wsa_pkg::fifo_stat_type q_stat,
   output logic                   q_pop,
   output logic                   init_done,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wsa_pkg::rsp_type       rsp_data
);

   localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BINS - 1);

   // upper half near zone, lower half far zone
   logic [63:0]                mem [BINS];
   logic [63:0]                rd_ff;

   wsa_pkg::back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0]          clr_ff, clr_in;
   wsa_pkg::cmd_type           cmd_ff, cmd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   wsa_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       out_free;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [63:0]                wr_data;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       rsp_load;
   wsa_pkg::rsp_type           rsp_next;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsa_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = wsa_pkg::ST_IDLE;
            end
         end
         wsa_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = wsa_pkg::ST_EXEC;
            end
         end
         wsa_pkg::ST_EXEC: begin
            if (cmd_ff.kind == wsa_pkg::CMD_ACC || out_free) begin
               state_in = wsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = ADDR_W'(q_cmd.bin);
      wr_en    = 1'b0;
      wr_addr  = ADDR_W'(cmd_ff.bin);
      wr_data  = '0;
      rsp_load = 1'b0;
      rsp_next = '0;
      clr_in   = clr_ff;
      unique case (state_ff)
         wsa_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         wsa_pkg::ST_IDLE: begin
            q_pop = !q_stat.empty;
            rd_en = !q_stat.empty;
         end
         wsa_pkg::ST_EXEC: begin
            case (cmd_ff.kind)
               wsa_pkg::CMD_ACC: begin
                  wr_en   = 1'b1;
                  wr_data = {rd_ff[63:32] + 32'(cmd_ff.dm), rd_ff[31:0] + 32'(cmd_ff.db)};
               end
               wsa_pkg::CMD_READ: begin
                  wr_en            = out_free;
                  rsp_load         = out_free;
                  rsp_next.m_count = wsa_pkg::sat16(rd_ff[63:32]);
                  rsp_next.b_count = wsa_pkg::sat16(rd_ff[31:0]);
               end
               wsa_pkg::CMD_NULL: begin
                  rsp_load = out_free;
               end
               default: begin
                  rsp_load = 1'b0;
               end
            endcase
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      cmd_in       = q_pop ? q_cmd : cmd_ff;
      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsa_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign init_done = (state_ff != wsa_pkg::ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/window_spectrum_accumulator.sv
// two-channel time-window spectrum accumulator
// req channel: one transaction per item, req_data carries action, bin and the
//   cumulative far-zone and near-zone counts. an accumulate item adds the raw
//   counts at bin 0, else the 16-bit wrapped difference from the previous
//   accumulate item, to the 32-bit bins. a read item returns both bins of one
//   index, saturated to 16 bits, and clears them.
// rsp channel: one transaction per read item, none per accumulate item.
//   a read beyond BINS returns zeros and clears nothing.
// read path: command queue, bin memory read, then the result register.
// item flow: the back end takes the next item only after the last one's
//   read-modify-write on the bin memory (read, then write back). a 4-entry
//   command queue from front end to memory takes short bursts at 1 per cycle.
// reset: after reset the bins are swept to zero, BINS cycles with req_ready
//   low; the previous counts are cleared at once.
// a stalled receiver holds the result register; the queue fills and then
//   req_ready drops until the result is taken.
`include "window_spectrum_accumulator_assert.svh"

module window_spectrum_accumulator #(
   parameter int BINS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wsa_pkg::rsp_type rsp_data
);

   logic                   init_done;
   logic                   q_push;
   logic                   q_pop;
   wsa_pkg::cmd_type       q_in;
   wsa_pkg::cmd_type       q_head;
   wsa_pkg::fifo_stat_type q_stat;

   wsa_front #(
      .BINS(BINS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .init_done(init_done),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_cmd    (q_in)
   );

   wsa_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   wsa_back #(
      .BINS(BINS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_cmd    (q_head),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .init_done(init_done),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   `WSA_ASSERT_NOW(a_no_overflow, clock, reset, q_stat.full, !q_push)
   `WSA_ASSERT_NOW(a_no_pop_empty, clock, reset, q_stat.empty, !q_pop)
   `WSA_ASSERT_NOW(a_idle_in_clear, clock, reset, !init_done, !q_push && !q_pop)
   `WSA_ASSERT_NEXT(a_init_sticks, clock, reset, init_done, init_done)

endmodule

// File: tb/tb_window_spectrum_accumulator.sv
module tb_window_spectrum_accumulator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BINS = 1024;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   wsa_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   wsa_pkg::rsp_type rsp_data;

   wsa_pkg::req_type pending_requests[$];
   wsa_pkg::rsp_type expected_counts[$];

   logic [31:0] near_bins[NUM_BINS];
   logic [31:0] far_bins[NUM_BINS];
   logic [15:0] last_near = '0;
   logic [15:0] last_far  = '0;

   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   int  rx_hold_left       = 0;
   int  mismatch_count     = 0;
   int  queued_total       = 0;
   bit  req_took           = 1'b0;

   window_spectrum_accumulator #(.BINS(NUM_BINS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] saturate_count(logic [31:0] total);
      return (total > 32'h0000_FFFF) ? 16'hFFFF : total[15:0];
   endfunction

   // spectrum state update for one accepted transaction
   function automatic void update_spectrum(wsa_pkg::req_type r);
      logic [15:0]      d_near;
      logic [15:0]      d_far;
      wsa_pkg::rsp_type res;
      if (r.action == wsa_pkg::ACT_ACC) begin
         if (r.bin == '0) begin
            d_near = r.m_cumulative;
            d_far  = r.b_cumulative;
         end else begin
            d_near = r.m_cumulative - last_near;
            d_far  = r.b_cumulative - last_far;
         end
         if (int'(r.bin) < NUM_BINS) begin
            near_bins[r.bin] = near_bins[r.bin] + {16'd0, d_near};
            far_bins[r.bin]  = far_bins[r.bin] + {16'd0, d_far};
         end
         last_near = r.m_cumulative;
         last_far  = r.b_cumulative;
      end else begin
         if (int'(r.bin) < NUM_BINS) begin
            res.m_count = saturate_count(near_bins[r.bin]);
            res.b_count = saturate_count(far_bins[r.bin]);
            near_bins[r.bin] = '0;
            far_bins[r.bin]  = '0;
         end else begin
            res = '0;
         end
         expected_counts.push_back(res);
      end
   endfunction

   // request side: previous transaction taken or channel empty, then maybe offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side backpressure, with an optional long hold-off
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      wsa_pkg::rsp_type want;
      req_took = !reset && req_valid && req_ready;
      if (req_took)
         update_spectrum(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected transaction: m_count=%0d b_count=%0d",
                   rsp_data.m_count, rsp_data.b_count);
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_data.m_count !== want.m_count) begin
               $error("m_count: expected %0d, actual %0d", want.m_count, rsp_data.m_count);
               mismatch_count++;
            end
            if (rsp_data.b_count !== want.b_count) begin
               $error("b_count: expected %0d, actual %0d", want.b_count, rsp_data.b_count);
               mismatch_count++;
            end
         end
      end
   end

   task automatic push_req(logic act, logic [9:0] bin_idx, logic [15:0] far,
                           logic [15:0] near);
      wsa_pkg::req_type r;
      r.action       = act;
      r.bin          = bin_idx;
      r.b_cumulative = far;
      r.m_cumulative = near;
      pending_requests.push_back(r);
      queued_total++;
   endtask

   function automatic logic [15:0] count_step();
      return ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300));
   endfunction

   // one window scan from bin 0 with rising, wrapping counts, then up to three reads of its bins
   task automatic queue_scan();
      int          len;
      int          reads;
      logic [15:0] near_run;
      logic [15:0] far_run;
      len      = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
      near_run = 16'($urandom);
      far_run  = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         push_req(wsa_pkg::ACT_ACC, 10'(i), far_run, near_run);
         near_run += count_step();
         far_run  += count_step();
      end
      reads = $urandom_range(3);
      for (int i = 0; i < reads; i++)
         push_req(wsa_pkg::ACT_READ, 10'($urandom_range(len - 1)), 16'($urandom),
                  16'($urandom));
   endtask

   task automatic queue_random_items(int count);
      int target;
      int pick;
      target = queued_total + count;
      while (queued_total < target) begin
         pick = $urandom_range(99);
         if (pick < 70)
            queue_scan();
         else if (pick < 85)
            push_req(wsa_pkg::ACT_READ, 10'($urandom), 16'($urandom), 16'($urandom));
         else
            push_req(wsa_pkg::ACT_ACC, 10'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic wait_all_sent();
      while (pending_requests.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      foreach (near_bins[i]) begin
         near_bins[i] = '0;
         far_bins[i]  = '0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed corners
      push_req(wsa_pkg::ACT_READ, 10'd0, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_ACC, 10'd0, 16'hFFFF, 16'hFFFF);
      push_req(wsa_pkg::ACT_ACC, 10'd0, 16'hFFFF, 16'hFFFF);
      push_req(wsa_pkg::ACT_READ, 10'd0, 16'hFFFF, 16'hFFFF);
      push_req(wsa_pkg::ACT_READ, 10'd0, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_ACC, 10'd0, 16'd20, 16'd10);
      push_req(wsa_pkg::ACT_ACC, 10'd1, 16'd18, 16'd15);
      push_req(wsa_pkg::ACT_ACC, 10'd1023, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_READ, 10'd1, 16'hAAAA, 16'h5555);
      push_req(wsa_pkg::ACT_READ, 10'd1023, 16'h5555, 16'hAAAA);
      push_req(wsa_pkg::ACT_READ, 10'd0, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_ACC, 10'd5, 16'h1234, 16'h8765);
      push_req(wsa_pkg::ACT_ACC, 10'd3, 16'h1000, 16'h8000);
      push_req(wsa_pkg::ACT_READ, 10'd5, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_READ, 10'd3, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_ACC, 10'd0, 16'hFFFF, 16'h0000);
      push_req(wsa_pkg::ACT_ACC, 10'd2, 16'h0000, 16'hFFFF);
      push_req(wsa_pkg::ACT_ACC, 10'd2, 16'hFFFF, 16'hFFFF);
      push_req(wsa_pkg::ACT_READ, 10'd2, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_READ, 10'd0, 16'h0000, 16'h0000);
      push_req(wsa_pkg::ACT_READ, 10'd1023, 16'hFFFF, 16'hFFFF);
      push_req(wsa_pkg::ACT_READ, 10'd512, 16'h0000, 16'h0000);
      wait_all_sent();

      // random traffic under each idling mix
      queue_random_items(235);
      wait_all_sent();
      sender_idle_pct = 54;
      queue_random_items(235);
      wait_all_sent();
      sender_idle_pct    = 0;
      receiver_stall_pct = 54;
      queue_random_items(235);
      wait_all_sent();
      sender_idle_pct    = 34;
      receiver_stall_pct = 34;
      queue_random_items(235);
      wait_all_sent();

      // long receiver hold-off while reads keep coming
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      rx_hold_left       = 300;
      for (int i = 0; i < 70; i++) begin
         if ($urandom_range(3) != 0)
            push_req(wsa_pkg::ACT_READ, 10'($urandom_range(15)), 16'($urandom),
                     16'($urandom));
         else
            queue_scan();
      end
      wait_all_sent();

      while (expected_counts.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_counts.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/wsa_pkg.sv
rtl/wsa_fifo.sv
rtl/wsa_front.sv
rtl/wsa_back.sv
rtl/window_spectrum_accumulator.sv
tb/tb_window_spectrum_accumulator.sv
